// File: src/lhs_pkg.sv
// Package for the Latin hypercube sample generator: constants, types and
// the command/status structs between controller and datapath. No dependencies.
package lhs_pkg;

  localparam int MaxPoints    = 1024;
  localparam int MaxVariables = 64;
  localparam int FracBits     = 16;
  localparam int PtW          = $clog2(MaxPoints);
  localparam int VarW         = $clog2(MaxVariables);
  localparam int CoordW       = FracBits + 1;
  localparam int CntW         = PtW + 1;
  localparam int VcntW        = VarW + 1;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 31;

  localparam logic [30:0] PmMult = 31'd16807;
  localparam logic [30:0] PmMod  = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPointCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegVariableCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSampleMode    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStartSeed     = 2'd3;

  // Sample modes.
  localparam logic [1:0] ModeCentered = 2'd0;
  localparam logic [1:0] ModeJittered = 2'd1;
  localparam logic [1:0] ModeEdge     = 2'd2;
  localparam logic [1:0] ModePlain    = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;      // latch item, apply restart and wraps
    logic fill_wr;    // write table[idx] = idx
    logic draw;       // advance generator
    logic shuf_rd_i;  // read table[i], compute partner j
    logic shuf_rd_j;  // read table[j]
    logic shuf_wr_i;  // write table[i] = table[j]
    logic shuf_wr_j;  // write table[j] = old table[i]
    logic idx_inc;    // step shuffle/fill index
    logic idx_clr;
    logic perm_rd;    // read table[point_position]
    logic div_go;     // launch divider
    logic out_load;   // load result register
  } lhs_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_shuffle;
    logic use_divider;
    logic idx_last;
    logic div_done;
  } lhs_stat_t;

  typedef struct packed {
    logic [CoordW-1:0] coordinate;
    logic [PtW-1:0]    stratum;
    logic [VarW-1:0]   variable_index;
    logic              last_of_variable;
    logic              last_of_set;
  } lhs_result_t;

endpackage

// File: src/lhs_if.sv
// Channel interfaces: valid/ready handshake with payload.
// No dependencies.
interface lhs_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lhs_res_if;
  logic valid;
  logic ready;
  logic [16:0] coordinate;
  logic [9:0]  stratum;
  logic [5:0]  variable_index;
  logic        last_of_variable;
  logic        last_of_set;
  modport source (output valid, output coordinate, output stratum, output variable_index,
                  output last_of_variable, output last_of_set, input ready);
  modport sink (input valid, input coordinate, input stratum, input variable_index,
                input last_of_variable, input last_of_set, output ready);
endinterface

interface lhs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/lhs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lhs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wr_data,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write when enabled; the read is registered and returns the old contents on a write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end
endmodule

// File: src/lhs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lhs_pkg.
module lhs_div
  import lhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [27:0] dividend,
  input  logic [11:0] divisor,
  output logic        done,
  output logic [27:0] quotient
);
  localparam int Steps = 28;

  logic [4:0]  count;
  logic        busy;
  logic [11:0] rem;
  logic [27:0] quo;
  logic [11:0] dsr;
  logic [12:0] trial;

  assign trial = {rem, quo[27]} - {1'b0, dsr};

  // One shift-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[12]) begin
        rem <= trial[11:0];
        quo <= {quo[26:0], 1'b1};
      end else begin
        rem <= {rem[10:0], quo[27]};
        quo <= {quo[26:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
endmodule

// File: src/lhs_dp.sv
// Datapath: configuration registers, generator, table RAM, divider, result.
// Depends on lhs_pkg, lhs_ram and lhs_div.
module lhs_dp
  import lhs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CfgDataW-1:0]     cfg_data,
  input  logic                    req_restart,
  input  lhs_pkg::lhs_cmd_t       cmd,
  output lhs_pkg::lhs_stat_t      stat,
  output lhs_pkg::lhs_result_t    result
);
  logic [10:0] point_count;
  logic [6:0]  variable_count;
  logic [1:0]  sample_mode;
  logic [30:0] start_seed;

  logic [30:0] rng_state;
  logic [PtW-1:0]  point_position;
  logic [VarW-1:0] variable_position;
  logic [CntW-1:0] n;
  logic [VcntW-1:0] nv;
  logic [PtW-1:0]  idx;
  logic [PtW-1:0]  jdx;
  logic [PtW-1:0]  val_i;
  logic [PtW-1:0]  ram_addr;
  logic [PtW-1:0]  ram_wdata;
  logic            ram_we;
  logic [PtW-1:0]  ram_rdata;

  // Effective point and variable counts.
  always_comb begin
    if (point_count == '0) n = CntW'(1);
    else if (point_count > 11'(MaxPoints)) n = CntW'(MaxPoints);
    else n = point_count[CntW-1:0];
    if (variable_count == '0) nv = VcntW'(1);
    else if (variable_count > 7'(MaxVariables)) nv = VcntW'(MaxVariables);
    else nv = variable_count[VcntW-1:0];
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= 11'd1;
      variable_count <= 7'd1;
      sample_mode    <= ModeJittered;
      start_seed     <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPointCount:    point_count    <= cfg_data[10:0];
        RegVariableCount: variable_count <= cfg_data[6:0];
        RegSampleMode:    sample_mode    <= cfg_data[1:0];
        RegStartSeed:     start_seed     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Park-Miller step: 31x15 product, folded modulo 2^31-1 in two passes.
  logic [45:0] prod;
  logic [31:0] fold1;
  logic [30:0] fold2;
  logic [30:0] draw_val;
  assign prod  = rng_state * PmMult[14:0];
  assign fold1 = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
  assign fold2 = fold1[30:0] + {30'd0, fold1[31]};
  assign draw_val = (fold2 == PmMod || fold2 == '0) ? 31'd1 : fold2;

  // Generator state and positions.
  logic [30:0] seed_eff;
  assign seed_eff = (start_seed == '0 || start_seed == PmMod) ? 31'd1 : start_seed;

  logic lastv;
  logic lasts;
  assign lastv = ({1'b0, point_position} == n - CntW'(1));
  assign lasts = lastv && ({1'b0, variable_position} == nv - VcntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state         <= 31'd1;
      point_position    <= '0;
      variable_position <= '0;
    end else begin
      if (cmd.start) begin
        if (req_restart) begin
          rng_state <= seed_eff;
          point_position    <= '0;
          variable_position <= '0;
        end else begin
          if ({1'b0, point_position} >= n) point_position <= '0;
          if ({1'b0, variable_position} >= nv) variable_position <= '0;
        end
      end else if (cmd.draw) begin
        rng_state <= draw_val;
      end
      if (cmd.out_load) begin
        if (lastv) begin
          point_position    <= '0;
          variable_position <= lasts ? '0 : variable_position + VarW'(1);
        end else begin
          point_position <= point_position + PtW'(1);
        end
      end
    end
  end

  // Shuffle index and partner: j = i + ((s*(n-i))>>31), registered.
  logic [CntW-1:0] remain;
  logic [41:0]     jprod;
  logic [CntW:0]   jsum;
  assign remain = n - {1'b0, idx};
  assign jprod  = rng_state * remain;
  assign jsum   = {2'b00, idx} + {1'b0, jprod[41:31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + PtW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shuf_rd_i) begin
      jdx <= (jsum > {1'b0, n - CntW'(1)}) ? PtW'(n - CntW'(1)) : jsum[PtW-1:0];
    end
    if (cmd.shuf_rd_j) val_i <= ram_rdata;
  end

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = idx;
    priority if (cmd.fill_wr) begin
      ram_we = 1'b1;
    end else if (cmd.shuf_rd_j) begin
      ram_addr = jdx;
    end else if (cmd.shuf_wr_i) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.shuf_wr_j) begin
      ram_we    = 1'b1;
      ram_addr  = jdx;
      ram_wdata = val_i;
    end else if (cmd.perm_rd) begin
      ram_addr = point_position;
    end
  end

  lhs_ram #(.Width(PtW), .Depth(MaxPoints)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .addr    (ram_addr),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // Divider operands per mode.
  logic [PtW-1:0]   p;
  logic [27:0]      dividend;
  logic [11:0]      divisor;
  logic [FracBits-1:0] r;
  logic             div_done;
  logic [27:0]      quotient;
  assign p = ram_rdata;
  assign r = rng_state[30 -: FracBits];

  always_comb begin
    unique case (sample_mode)
      ModeCentered: begin
        dividend = {1'b0, p, 1'b1, 16'd0} + 28'(n);
        divisor  = {n, 1'b0};
      end
      ModeJittered: begin
        dividend = {2'b00, p, r};
        divisor  = {1'b0, n};
      end
      default: begin
        dividend = {2'b00, p, 16'd0} + 28'((n - CntW'(1)) >> 1);
        divisor  = {1'b0, n - CntW'(1)};
      end
    endcase
  end

  logic [27:0] op_a;
  logic [11:0] op_b;
  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      op_a <= dividend;
      op_b <= divisor;
    end
  end

  // The divider is launched the cycle after operands are captured.
  logic div_go_q;
  always_ff @(posedge clk) begin
    if (rst) div_go_q <= 1'b0;
    else div_go_q <= cmd.div_go;
  end

  lhs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go_q),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quotient (quotient)
  );

  logic [PtW-1:0] p_q;
  always_ff @(posedge clk) begin
    if (cmd.div_go) p_q <= p;
  end

  // Result register.
  logic [CoordW-1:0] coord;
  always_comb begin
    if (sample_mode == ModePlain) begin
      coord = {1'b0, r};
    end else if (sample_mode == ModeEdge && n == CntW'(1)) begin
      coord = CoordW'(1) << (FracBits - 1);
    end else if (quotient > 28'(1 << FracBits)) begin
      coord = CoordW'(1) << FracBits;
    end else begin
      coord = quotient[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.coordinate       <= coord;
      result.stratum          <= stat.use_divider ? p_q : '0;
      result.variable_index   <= variable_position;
      result.last_of_variable <= lastv;
      result.last_of_set      <= lasts;
    end
  end

  assign stat.use_divider  = !(sample_mode == ModePlain ||
                               (sample_mode == ModeEdge && n == CntW'(1)));
  assign stat.need_shuffle = stat.use_divider && (point_position == '0);
  assign stat.idx_last     = ({1'b0, idx} == n - CntW'(1));
  assign stat.div_done     = div_done;
endmodule

// File: src/lhs_ctrl.sv
// Controller state machine: sequences fill, shuffle, draw, divide, output.
// Depends on lhs_pkg.
module lhs_ctrl
  import lhs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lhs_pkg::lhs_stat_t stat,
  input  logic [1:0]         mode,
  output lhs_pkg::lhs_cmd_t  cmd
);
  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_CHECK  = 13'h0002,
    S_FILL   = 13'h0004,
    S_DRAW   = 13'h0008,
    S_RDI    = 13'h0010,
    S_RDJ    = 13'h0020,
    S_WRI    = 13'h0040,
    S_WRJ    = 13'h0080,
    S_JIT    = 13'h0100,
    S_PERM   = 13'h0200,
    S_GO     = 13'h0400,
    S_DIV    = 13'h0800,
    S_OUT    = 13'h1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_pending;
  logic   loading;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Output register valid; the next item may start while a result waits.
  always_ff @(posedge clk) begin
    if (rst) out_pending <= 1'b0;
    else if (loading) out_pending <= 1'b1;
    else if (out_ready) out_pending <= 1'b0;
  end
  assign out_valid = out_pending;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    loading    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.idx_clr = 1'b1;
        if (stat.need_shuffle) state_next = S_FILL;
        else if (stat.use_divider) state_next = (mode == ModeJittered) ? S_JIT : S_PERM;
        else if (mode == ModePlain) state_next = S_DRAW;
        else state_next = S_OUT;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_DRAW;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DRAW: begin
        // Generator advance: shuffle step or plain draw.
        cmd.draw = 1'b1;
        if (!stat.use_divider) state_next = S_OUT;
        else state_next = S_RDI;
      end
      S_RDI: begin
        cmd.shuf_rd_i = 1'b1;
        state_next    = S_RDJ;
      end
      S_RDJ: begin
        cmd.shuf_rd_j = 1'b1;
        state_next    = S_WRI;
      end
      S_WRI: begin
        cmd.shuf_wr_i = 1'b1;
        state_next    = S_WRJ;
      end
      S_WRJ: begin
        cmd.shuf_wr_j = 1'b1;
        if (stat.idx_last) begin
          state_next = (mode == ModeJittered) ? S_JIT : S_PERM;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_DRAW;
        end
      end
      S_JIT: begin
        // Jitter draw, taken after any shuffle draws.
        cmd.draw   = 1'b1;
        state_next = S_PERM;
      end
      S_PERM: begin
        cmd.perm_rd = 1'b1;
        state_next  = S_GO;
      end
      S_GO: begin
        // The table read is valid here, so the operands are captured.
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_pending || out_ready) begin
          cmd.out_load = 1'b1;
          loading      = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) loading |-> !out_pending || out_ready)
    else $error("result register overwritten");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("item accepted outside idle");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("loaded result not shown");
endmodule

// File: src/latin_hypercube_sample_generator_top.sv
// Top level of the Latin hypercube sample generator.
// Depends on lhs_pkg, lhs_if, lhs_ctrl and lhs_dp.
//
//  Channel  Role  Carries
//  req      sink  restart
//  res      src   coordinate, stratum, variable_index, last flags
//  cfg      sink  index, data (register writes)
//
// A centered, edge or jittered item runs the 28-step divider, and a jittered
// one first takes an extra draw; a plain item, or edge with one stratum, skips
// the divider. The first point of a variable adds a table fill and a shuffle
// through the single table RAM port. Reset is synchronous and clears control
// state. A finished result waits in the output register while the next item
// starts; that item stalls before its own load until the result is taken.
module latin_hypercube_sample_generator_top
  import lhs_pkg::*;
(
  input logic clk,
  input logic rst,
  lhs_req_if.sink   req,
  lhs_res_if.source res,
  lhs_cfg_if.sink   cfg
);
  lhs_cmd_t    cmd;
  lhs_stat_t   stat;
  lhs_result_t result;
  logic [1:0]  mode_seen;
  logic [1:0]  mode_q;

  assign cfg.ready = 1'b1;
  assign mode_seen = (cfg.valid && cfg.index == RegSampleMode) ? cfg.data[1:0] : mode_q;

  always_ff @(posedge clk) begin
    if (rst) mode_q <= ModeJittered;
    else if (cfg.valid && cfg.index == RegSampleMode) mode_q <= cfg.data[1:0];
  end

  lhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .mode      (mode_seen),
    .cmd       (cmd)
  );

  lhs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .req_restart (req.restart),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

  assign res.coordinate       = result.coordinate;
  assign res.stratum          = result.stratum;
  assign res.variable_index   = result.variable_index;
  assign res.last_of_variable = result.last_of_variable;
  assign res.last_of_set      = result.last_of_set;
endmodule

// File: tb/sv/latin_hypercube_sample_generator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Latin hypercube sample generator top level.
// Depends on lhs_pkg, the lhs_if channel interfaces and the RTL under src.
module latin_hypercube_sample_generator_top_tb;
  import lhs_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int SettleCycles = 60;

  logic clk;
  logic rst;

  lhs_req_if req_ch();
  lhs_res_if res_ch();
  lhs_cfg_if cfg_ch();

  latin_hypercube_sample_generator_top uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Predictor copy of the registers and the block state.
  logic [10:0] pr_points;
  logic [6:0] pr_vars;
  logic [1:0] pr_mode;
  logic [30:0] pr_seed;
  logic [PtW-1:0] pr_table [MaxPoints];
  bit pr_written [MaxPoints];
  logic [30:0] pr_rng;
  int unsigned pr_point;
  int unsigned pr_var;

  lhs_result_t coord_queue[$];
  int mismatches;
  int results_seen;
  int items_sent;
  int restarts_sent;
  int cycles;
  bit steady;
  int hold_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle counter and timeout.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles, %0d coordinates still due", cycles,
                 coord_queue.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int unsigned eff_points();
    if (pr_points == 0) return 1;
    if (pr_points > MaxPoints) return MaxPoints;
    return pr_points;
  endfunction

  function automatic int unsigned eff_vars();
    if (pr_vars == 0) return 1;
    if (pr_vars > MaxVariables) return MaxVariables;
    return pr_vars;
  endfunction

  // Advance the Park-Miller generator by one draw.
  function automatic logic [30:0] draw_rng();
    longint unsigned s;
    s = (longint'(pr_rng) * 16807) % 64'd2147483647;
    if (s == 0) s = 1;
    pr_rng = s[30:0];
    return pr_rng;
  endfunction

  // True when the next item, without restart, would read a table entry never written.
  function automatic bit reads_unwritten();
    int unsigned n;
    int unsigned pos;
    n = eff_points();
    pos = (pr_point >= n) ? 0 : pr_point;
    if (pr_mode == ModePlain || (pr_mode == ModeEdge && n == 1) || pos == 0) return 0;
    return !pr_written[pos];
  endfunction

  // Work out the coordinate that one request item produces, updating the state.
  function automatic lhs_result_t predict_coordinate(bit rs);
    lhs_result_t r;
    int unsigned n;
    int unsigned nv;
    longint unsigned coord;
    longint unsigned p;
    longint unsigned s;
    longint unsigned j;
    longint unsigned d;
    logic [PtW-1:0] t;
    bit lastv;
    n = eff_points();
    nv = eff_vars();
    coord = 0;
    p = 0;
    if (rs) begin
      pr_rng = (pr_seed == 0 || pr_seed == 31'h7FFF_FFFF) ? 31'd1 : pr_seed;
      pr_point = 0;
      pr_var = 0;
    end
    if (pr_point >= n) pr_point = 0;
    if (pr_var >= nv) pr_var = 0;
    if (pr_mode == ModePlain) begin
      coord = draw_rng() >> 15;
    end else if (pr_mode == ModeEdge && n == 1) begin
      coord = 64'd32768;
    end else begin
      if (pr_point == 0) begin
        for (int i = 0; i < n; i++) begin
          pr_table[i] = PtW'(i);
          pr_written[i] = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
          s = draw_rng();
          j = i + ((s * (n - i)) >> 31);
          if (j > n - 1) j = n - 1;
          t = pr_table[i];
          pr_table[i] = pr_table[j];
          pr_table[j] = t;
        end
      end
      p = pr_table[pr_point];
      if (pr_mode == ModeCentered) begin
        coord = (((2 * p + 1) << 16) + n) / (2 * n);
      end else if (pr_mode == ModeJittered) begin
        coord = ((p << 16) + (draw_rng() >> 15)) / n;
      end else begin
        d = n - 1;
        coord = ((p << 16) + d / 2) / d;
      end
      if (coord > 65536) coord = 65536;
    end
    lastv = (pr_point == n - 1);
    r.coordinate = coord[16:0];
    r.stratum = p[9:0];
    r.variable_index = pr_var[5:0];
    r.last_of_variable = lastv;
    r.last_of_set = lastv && (pr_var == nv - 1);
    if (lastv) begin
      pr_point = 0;
      pr_var = r.last_of_set ? 0 : pr_var + 1;
    end else begin
      pr_point++;
    end
    return r;
  endfunction

  // Result side: random or held-off ready, and a field-by-field check of each item.
  initial begin
    lhs_result_t want;
    res_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready && !rst) begin
        results_seen++;
        if (coord_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected coordinate %0d at cycle %0d",
                                         res_ch.coordinate, cycles);
        end else begin
          want = coord_queue.pop_front();
          if (res_ch.coordinate !== want.coordinate || res_ch.stratum !== want.stratum ||
              res_ch.variable_index !== want.variable_index ||
              res_ch.last_of_variable !== want.last_of_variable ||
              res_ch.last_of_set !== want.last_of_set) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Item %0d: want c=%0d s=%0d v=%0d lv=%0b ls=%0b, %s",
                       results_seen, want.coordinate, want.stratum, want.variable_index,
                       want.last_of_variable, want.last_of_set,
                       $sformatf("got c=%0d s=%0d v=%0d lv=%0b ls=%0b",
                                 res_ch.coordinate, res_ch.stratum,
                                 res_ch.variable_index, res_ch.last_of_variable,
                                 res_ch.last_of_set));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
      end
    end
  end

  // Send one request item; restart is forced where the table would be read unwritten.
  task automatic send_item(bit rs);
    if (!steady && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (reads_unwritten()) rs = 1;
    coord_queue.push_back(predict_coordinate(rs));
    items_sent++;
    if (rs) restarts_sent++;
    req_ch.valid <= 1'b1;
    req_ch.restart <= rs;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Let every due coordinate arrive and the block settle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (coord_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [30:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      RegPointCount: pr_points = val[10:0];
      RegVariableCount: pr_vars = val[6:0];
      RegSampleMode: pr_mode = val[1:0];
      default: pr_seed = val;
    endcase
  endtask

  task automatic configure(int n, int nv, logic [1:0] mode, logic [30:0] seed);
    write_register(RegPointCount, 31'(n));
    write_register(RegVariableCount, 31'(nv));
    write_register(RegSampleMode, {29'd0, mode});
    write_register(RegStartSeed, seed);
  endtask

  task automatic send_run(int count, bit first_restart);
    for (int i = 0; i < count; i++) send_item(i == 0 ? first_restart : 1'b0);
  endtask

  // Default registers after reset, without any write.
  task automatic test_reset_defaults();
    send_run(3, 0);
    wait_idle();
  endtask

  // Register extremes, bad seeds and the single-stratum edge case.
  task automatic test_extremes();
    configure(0, 0, ModeEdge, 31'd12345);
    send_run(2, 1);
    wait_idle();
    configure(3, 2, ModePlain, 31'd0);
    send_run(2, 1);
    wait_idle();
    write_register(RegStartSeed, 31'h7FFF_FFFF);
    send_run(1, 1);
    wait_idle();
    configure(2047, 127, ModeCentered, 31'h7FFF_FFFE);
    send_run(2, 1);
    wait_idle();
    configure(2, 1, ModeEdge, 31'h2AAA_5555);
    send_run(2, 1);
    wait_idle();
  endtask

  // Each sample mode over two short variables.
  task automatic test_modes();
    for (int m = 0; m < 4; m++) begin
      configure(3, 2, m[1:0], 31'($urandom_range(1, 32'h7FFF_FFFE)));
      send_run(4, 1);
      wait_idle();
    end
  endtask

  // Point count and variable count lowered part way through a set.
  task automatic test_shrinking();
    configure(8, 4, ModeCentered, 31'd777);
    send_run(6, 1);
    wait_idle();
    // Position now beyond the new count: the variable starts again.
    write_register(RegPointCount, 31'd4);
    send_run(2, 0);
    wait_idle();
    // Eight strata again, now jittered, started afresh by a restart.
    write_register(RegPointCount, 31'd8);
    write_register(RegSampleMode, {29'd0, ModeJittered});
    send_run(3, 1);
    wait_idle();
    write_register(RegPointCount, 31'd3);
    send_run(3, 0);
    wait_idle();
    // Variable index beyond the new count wraps to zero.
    configure(2, 4, ModeEdge, 31'd99);
    send_run(6, 1);
    wait_idle();
    write_register(RegVariableCount, 31'd2);
    send_run(3, 0);
    wait_idle();
  endtask

  // Receiver holds off while items keep coming; then the sender drains.
  task automatic test_backpressure();
    configure(5, 3, ModeJittered, 31'd4242);
    steady = 1;
    hold_left = 600;
    send_run(20, 1);
    wait_idle();
    send_run(10, 0);
    wait_idle();
    steady = 0;
  endtask

  // Random settings, mostly small point counts, each phase a run of items.
  task automatic test_random(int target);
    int n;
    int nv;
    int roll;
    int phase;
    int count;
    logic [30:0] seed;
    phase = 0;
    while (items_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 70) n = $urandom_range(1, 8);
      else if (roll < 96) n = $urandom_range(9, 64);
      else n = $urandom_range(65, 2047);
      nv = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
      roll = $urandom_range(19);
      seed = (roll == 0) ? 31'd0 : (roll == 1) ? 31'h7FFF_FFFF : 31'($urandom);
      if ($urandom_range(3) == 0) write_register(RegPointCount, 31'(n));
      else configure(n, nv, 2'($urandom_range(3)), seed);
      steady = (phase == 5);
      count = $urandom_range(20, 80);
      for (int i = 0; i < count; i++)
        send_item(i == 0 ? 1'($urandom_range(1)) : ($urandom_range(9) == 0));
      wait_idle();
      phase++;
    end
    steady = 0;
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegPointCount;
    cfg_ch.data = '0;
    steady = 0;
    hold_left = 0;
    items_sent = 0;
    restarts_sent = 0;
    pr_points = 1;
    pr_vars = 1;
    pr_mode = ModeJittered;
    pr_seed = 1;
    pr_rng = 1;
    pr_point = 0;
    pr_var = 0;
    for (int i = 0; i < MaxPoints; i++) begin
      pr_table[i] = '0;
      pr_written[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_modes();
    test_shrinking();
    test_backpressure();
    test_random(1800);
    wait_idle();
    $display("Sent %0d request items (%0d restarts), checked %0d coordinates in %0d cycles.",
             items_sent, restarts_sent, results_seen, cycles);
    $display("All four modes, register extremes, bad seeds and count changes were covered.");
    if (mismatches == 0 && coord_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d coordinates missing", mismatches, coord_queue.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
